>>> src/spc_pkg.sv
// Shared types, constants and coding functions for the scrambled packet codec.
`default_nettype none
package spc_pkg;

   localparam int POS_W    = 6;
   localparam int SCR_LEN  = 35;
   localparam int XOR_LEN  = 28;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_SEED = 16'hb5d2;
   localparam logic [7:0]  PREAMBLE = 8'h55;

   // Configuration register indexes
   localparam logic [1:0] CSR_TX_ADDRESS     = 2'd0;
   localparam logic [1:0] CSR_ADDRESS_LENGTH = 2'd1;
   localparam logic [1:0] CSR_CRC_ENABLE     = 2'd2;
   localparam logic [1:0] CSR_NATIVE_MODE    = 2'd3;

   typedef logic [POS_W-1:0] pos_type;

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] c_init, input logic [7:0] v);
      logic [15:0] c;
      c = c_init ^ {v, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   function automatic logic [7:0] scr_lookup(input logic [5:0] idx);
      logic [7:0] s;
      case (idx)
         6'd0:  s = 8'he3;  6'd1:  s = 8'hb1;  6'd2:  s = 8'h4b;  6'd3:  s = 8'hea;
         6'd4:  s = 8'h85;  6'd5:  s = 8'hbc;  6'd6:  s = 8'he5;  6'd7:  s = 8'h66;
         6'd8:  s = 8'h0d;  6'd9:  s = 8'hae;  6'd10: s = 8'h8c;  6'd11: s = 8'h88;
         6'd12: s = 8'h12;  6'd13: s = 8'h69;  6'd14: s = 8'hee;  6'd15: s = 8'h1f;
         6'd16: s = 8'hc7;  6'd17: s = 8'h62;  6'd18: s = 8'h97;  6'd19: s = 8'hd5;
         6'd20: s = 8'h0b;  6'd21: s = 8'h79;  6'd22: s = 8'hca;  6'd23: s = 8'hcc;
         6'd24: s = 8'h1b;  6'd25: s = 8'h5d;  6'd26: s = 8'h19;  6'd27: s = 8'h10;
         6'd28: s = 8'h24;  6'd29: s = 8'hd3;  6'd30: s = 8'hdc;  6'd31: s = 8'h3f;
         6'd32: s = 8'h8e;  6'd33: s = 8'hc5;  6'd34: s = 8'h2f;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   function automatic logic [15:0] crc_xor_lookup(input logic [4:0] idx);
      logic [15:0] x;
      case (idx)
         5'd0:  x = 16'h0000; 5'd1:  x = 16'h3448; 5'd2:  x = 16'h9BA7; 5'd3:  x = 16'h8BBB;
         5'd4:  x = 16'h85E1; 5'd5:  x = 16'h3E8C; 5'd6:  x = 16'h451E; 5'd7:  x = 16'h18E6;
         5'd8:  x = 16'h6B24; 5'd9:  x = 16'hE7AB; 5'd10: x = 16'h3828; 5'd11: x = 16'h8148;
         5'd12: x = 16'hD461; 5'd13: x = 16'hF494; 5'd14: x = 16'h2503; 5'd15: x = 16'h691D;
         5'd16: x = 16'hFE8B; 5'd17: x = 16'h9BA7; 5'd18: x = 16'h8B17; 5'd19: x = 16'h2920;
         5'd20: x = 16'h8B5F; 5'd21: x = 16'h61B1; 5'd22: x = 16'hD391; 5'd23: x = 16'h7401;
         5'd24: x = 16'h2138; 5'd25: x = 16'h129F; 5'd26: x = 16'hB3A0; 5'd27: x = 16'h2988;
         default: x = 16'h0000;
      endcase
      return x;
   endfunction

endpackage
`default_nettype wire

>>> src/scrambled_packet_codec_unit.sv
// Top level of the scrambled packet codec: request register, step sequencer, response register.
//
// Usage:
//  - Requests (req_*) carry one byte: a transmit byte (req_kind 0) or a received
//    byte (req_kind 1). req_last_byte closes the packet; with req_no_data also set
//    the close carries no byte.
//  - Responses (rsp_*) carry one output byte each. One request yields 0 to 8
//    responses: in emulated transmit mode the first request of a packet also
//    sends the optional 0x55 preamble and the scrambled address, and the closing
//    request appends the two CRC bytes when CRC is enabled.
//  - The sequencer produces one response per cycle while the output has room, and
//    holds each request until its last response. A one-response request is taken
//    every cycle unless stalled; its response passes the request and response registers.
//  - The CRC advances one byte per cycle in the sequencer (when it is not stalled), which sets the pace.
//  - rsp_* sits in an output register; when it is stalled the sequencer holds,
//    and the request register holds the next byte until there is room.
//  - csr_* writes one configuration register per cycle; write only while idle.
//  - Reset (synchronous, active high) clears packet state, seeds the CRC with
//    0xb5d2 and returns the registers to native mode, 3-byte address, no CRC.
`default_nettype none
module scrambled_packet_codec_unit
   import spc_pkg::*;
#(
   parameter int MAX_PACKET = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [39:0] csr_wr_data,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   input  wire logic        req_no_data,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_is_rx,
   output logic             rsp_out_last,
   output logic             rsp_out_error
);

   localparam logic [6:0] MaxPkt = 7'(MAX_PACKET);

   typedef enum logic [2:0] {
      PH_NONE,
      PH_PRE,
      PH_ADDR,
      PH_DATA,
      PH_CRC_HI,
      PH_CRC_LO
   } phase_type;

   // configuration registers
   logic [39:0] tx_address_ff, tx_address_in;
   logic [2:0]  address_length_ff, address_length_in;
   logic        crc_enable_ff, crc_enable_in;
   logic        native_mode_ff, native_mode_in;

   // packet state
   pos_type     tx_pos_ff, tx_pos_in;
   pos_type     rx_pos_ff, rx_pos_in;
   logic [15:0] crc_ff, crc_in;
   logic        header_sent_ff, header_sent_in;

   // held request
   logic        cur_valid_ff, cur_valid_in;
   logic        cur_fresh_ff, cur_fresh_in;
   logic        cur_kind_ff, cur_kind_in;
   logic [7:0]  cur_byte_ff, cur_byte_in;
   logic        cur_last_ff, cur_last_in;
   logic        cur_present_ff, cur_present_in;
   phase_type   phase_ff, phase_in;
   logic [2:0]  hdr_idx_ff, hdr_idx_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_is_rx_ff, rsp_is_rx_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_error_ff, rsp_error_in;

   // step logic
   logic        out_room, step_fire, req_fire;
   logic [2:0]  al;
   logic        short_addr;
   phase_type   start_phase, eff_phase, next_phase;
   logic [2:0]  eff_idx, next_idx;
   logic        has_next, emit, emit_err;
   logic [7:0]  emit_byte;
   logic [2:0]  addr_sel;
   logic [7:0]  addr_enc;
   logic [5:0]  tx_scr_idx, rx_scr_idx;
   logic [6:0]  tx_need;
   logic        tx_emu_ok, tx_nat_ok, rx_ok;
   logic [6:0]  xor_sum;
   logic [4:0]  xor_idx;
   logic [15:0] crc_final;
   logic [7:0]  data_enc;
   pos_type     tx_pos_step, rx_pos_step;
   logic [15:0] crc_step;
   logic        header_sent_step;
   logic        emulated_tx;

   always_comb begin
      // effective address length, clamped to 3..5
      if (address_length_ff < 3'd3) begin
         al = 3'd3;
      end else if (address_length_ff > 3'd5) begin
         al = 3'd5;
      end else begin
         al = address_length_ff;
      end
      short_addr  = (al < 3'd4);
      emulated_tx = !cur_kind_ff && !native_mode_ff;

      out_room  = !rsp_valid_ff || rsp_ready;
      step_fire = cur_valid_ff && out_room;

      // first step of a freshly loaded request
      if (cur_kind_ff || native_mode_ff) begin
         start_phase = cur_present_ff ? PH_DATA : PH_NONE;
      end else if (!header_sent_ff) begin
         start_phase = short_addr ? PH_PRE : PH_ADDR;
      end else if (cur_present_ff) begin
         start_phase = PH_DATA;
      end else if (cur_last_ff && crc_enable_ff) begin
         start_phase = PH_CRC_HI;
      end else begin
         start_phase = PH_NONE;
      end
      eff_phase = cur_fresh_ff ? start_phase : phase_ff;
      eff_idx   = cur_fresh_ff ? 3'd0 : hdr_idx_ff;

      // address byte, sent last byte first
      addr_sel = al - 3'd1 - eff_idx;
      addr_enc = tx_address_ff[{addr_sel, 3'b000} +: 8] ^ scr_lookup({3'b000, eff_idx});

      // payload checks and coding
      tx_scr_idx = {3'b000, al} + tx_pos_ff;
      rx_scr_idx = {3'b000, al} + rx_pos_ff;
      tx_need    = {4'b0000, al} + {6'b000000, short_addr} + {1'b0, tx_pos_ff} + 7'd1
                   + (crc_enable_ff ? 7'd2 : 7'd0);
      tx_emu_ok  = (tx_need <= MaxPkt) && (tx_scr_idx < 6'(SCR_LEN));
      tx_nat_ok  = ({1'b0, tx_pos_ff} < MaxPkt);
      rx_ok      = ({1'b0, rx_pos_ff} < MaxPkt) && (rx_scr_idx < 6'(SCR_LEN));
      data_enc   = rev8(cur_byte_ff) ^ scr_lookup(tx_scr_idx);

      // closing CRC, table index saturates at its last entry
      xor_sum   = {4'b0000, al} - 7'd3 + {1'b0, tx_pos_ff};
      xor_idx   = (xor_sum > 7'(XOR_LEN - 1)) ? 5'(XOR_LEN - 1) : xor_sum[4:0];
      crc_final = crc_ff ^ crc_xor_lookup(xor_idx);

      // defaults
      has_next         = 1'b0;
      next_phase       = PH_NONE;
      next_idx         = 3'd0;
      emit             = 1'b0;
      emit_err         = 1'b0;
      emit_byte        = 8'h00;
      tx_pos_step      = tx_pos_ff;
      rx_pos_step      = rx_pos_ff;
      crc_step         = crc_ff;
      header_sent_step = header_sent_ff;

      case (eff_phase)
         PH_PRE: begin
            emit       = 1'b1;
            emit_byte  = PREAMBLE;
            has_next   = 1'b1;
            next_phase = PH_ADDR;
         end
         PH_ADDR: begin
            emit      = 1'b1;
            emit_byte = addr_enc;
            crc_step  = crc_byte(crc_ff, addr_enc);
            if (eff_idx == al - 3'd1) begin
               header_sent_step = 1'b1;
               if (cur_present_ff) begin
                  has_next   = 1'b1;
                  next_phase = PH_DATA;
               end else if (cur_last_ff && crc_enable_ff) begin
                  has_next   = 1'b1;
                  next_phase = PH_CRC_HI;
               end
            end else begin
               has_next   = 1'b1;
               next_phase = PH_ADDR;
               next_idx   = eff_idx + 3'd1;
            end
         end
         PH_DATA: begin
            emit = 1'b1;
            if (cur_kind_ff) begin
               if (rx_ok) begin
                  emit_byte   = rev8(cur_byte_ff) ^ rev8(scr_lookup(rx_scr_idx));
                  rx_pos_step = rx_pos_ff + pos_type'(1);
               end else begin
                  emit_err = 1'b1;
               end
            end else if (native_mode_ff) begin
               if (tx_nat_ok) begin
                  emit_byte   = cur_byte_ff;
                  tx_pos_step = tx_pos_ff + pos_type'(1);
               end else begin
                  emit_err = 1'b1;
               end
            end else begin
               if (tx_emu_ok) begin
                  emit_byte   = data_enc;
                  crc_step    = crc_byte(crc_ff, data_enc);
                  tx_pos_step = tx_pos_ff + pos_type'(1);
               end else begin
                  emit_err = 1'b1;
               end
            end
            if (emulated_tx && cur_last_ff && crc_enable_ff) begin
               has_next   = 1'b1;
               next_phase = PH_CRC_HI;
            end
         end
         PH_CRC_HI: begin
            emit       = 1'b1;
            emit_byte  = crc_final[15:8];
            has_next   = 1'b1;
            next_phase = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            emit      = 1'b1;
            emit_byte = crc_final[7:0];
         end
         default: begin
            // close without output: state is cleared below
         end
      endcase

      // a closing request returns its side to the packet start
      if (!has_next && cur_last_ff) begin
         if (cur_kind_ff) begin
            rx_pos_step = '0;
         end else begin
            tx_pos_step      = '0;
            header_sent_step = 1'b0;
            crc_step         = CRC_SEED;
         end
      end
   end

   assign req_ready = !cur_valid_ff || (step_fire && !has_next);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      // configuration writes
      tx_address_in     = tx_address_ff;
      address_length_in = address_length_ff;
      crc_enable_in     = crc_enable_ff;
      native_mode_in    = native_mode_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_TX_ADDRESS:     tx_address_in     = csr_wr_data;
            CSR_ADDRESS_LENGTH: address_length_in = csr_wr_data[2:0];
            CSR_CRC_ENABLE:     crc_enable_in     = csr_wr_data[0];
            CSR_NATIVE_MODE:    native_mode_in    = csr_wr_data[0];
            default: begin
            end
         endcase
      end

      // packet state commits on each step
      tx_pos_in      = step_fire ? tx_pos_step      : tx_pos_ff;
      rx_pos_in      = step_fire ? rx_pos_step      : rx_pos_ff;
      crc_in         = step_fire ? crc_step         : crc_ff;
      header_sent_in = step_fire ? header_sent_step : header_sent_ff;

      // held request and sequencer position
      cur_valid_in   = cur_valid_ff;
      cur_fresh_in   = cur_fresh_ff;
      cur_kind_in    = cur_kind_ff;
      cur_byte_in    = cur_byte_ff;
      cur_last_in    = cur_last_ff;
      cur_present_in = cur_present_ff;
      phase_in       = phase_ff;
      hdr_idx_in     = hdr_idx_ff;
      if (step_fire) begin
         if (has_next) begin
            cur_fresh_in = 1'b0;
            phase_in     = next_phase;
            hdr_idx_in   = next_idx;
         end else begin
            cur_valid_in = 1'b0;
         end
      end
      if (req_fire) begin
         cur_valid_in   = 1'b1;
         cur_fresh_in   = 1'b1;
         cur_kind_in    = req_kind;
         cur_byte_in    = req_data_byte;
         cur_last_in    = req_last_byte;
         cur_present_in = !(req_last_byte && req_no_data);
      end

      // response register
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_is_rx_in = rsp_is_rx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_error_in = rsp_error_ff;
      if (out_room) begin
         rsp_valid_in = step_fire && emit;
      end
      if (step_fire && emit) begin
         rsp_byte_in  = emit_err ? 8'h00 : emit_byte;
         rsp_is_rx_in = cur_kind_ff;
         rsp_last_in  = cur_last_ff && !has_next;
         rsp_error_in = emit_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_address_ff     <= '0;
         address_length_ff <= 3'd3;
         crc_enable_ff     <= 1'b0;
         native_mode_ff    <= 1'b1;
         tx_pos_ff         <= '0;
         rx_pos_ff         <= '0;
         crc_ff            <= CRC_SEED;
         header_sent_ff    <= 1'b0;
         cur_valid_ff      <= 1'b0;
         cur_fresh_ff      <= 1'b0;
         phase_ff          <= PH_NONE;
         hdr_idx_ff        <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         tx_address_ff     <= tx_address_in;
         address_length_ff <= address_length_in;
         crc_enable_ff     <= crc_enable_in;
         native_mode_ff    <= native_mode_in;
         tx_pos_ff         <= tx_pos_in;
         rx_pos_ff         <= rx_pos_in;
         crc_ff            <= crc_in;
         header_sent_ff    <= header_sent_in;
         cur_valid_ff      <= cur_valid_in;
         cur_fresh_ff      <= cur_fresh_in;
         phase_ff          <= phase_in;
         hdr_idx_ff        <= hdr_idx_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      // payload, no reset needed
      cur_kind_ff    <= cur_kind_in;
      cur_byte_ff    <= cur_byte_in;
      cur_last_ff    <= cur_last_in;
      cur_present_ff <= cur_present_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_is_rx_ff   <= rsp_is_rx_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_error_ff   <= rsp_error_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_out_is_rx = rsp_is_rx_ff;
   assign rsp_out_last  = rsp_last_ff;
   assign rsp_out_error = rsp_error_ff;

endmodule
`default_nettype wire

>>> test/codec_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Byte predictor and response scoreboard for the scrambled packet codec testbench.
package codec_scoreboard_pkg;

   localparam int MAX_PACKET   = 32;
   localparam int SCRAMBLE_LEN = 35;
   localparam int CRC_FIX_LEN  = 28;
   localparam bit [15:0] POLY      = 16'h1021;
   localparam bit [15:0] SEED      = 16'hb5d2;
   localparam bit [7:0]  SYNC_BYTE = 8'h55;

   localparam bit [7:0] SCRAMBLE [SCRAMBLE_LEN] = '{
      8'he3, 8'hb1, 8'h4b, 8'hea, 8'h85, 8'hbc, 8'he5, 8'h66,
      8'h0d, 8'hae, 8'h8c, 8'h88, 8'h12, 8'h69, 8'hee, 8'h1f,
      8'hc7, 8'h62, 8'h97, 8'hd5, 8'h0b, 8'h79, 8'hca, 8'hcc,
      8'h1b, 8'h5d, 8'h19, 8'h10, 8'h24, 8'hd3, 8'hdc, 8'h3f,
      8'h8e, 8'hc5, 8'h2f};

   // final xor on the CRC, picked by address length plus payload count
   localparam bit [15:0] CRC_FIX [CRC_FIX_LEN] = '{
      16'h0000, 16'h3448, 16'h9BA7, 16'h8BBB, 16'h85E1, 16'h3E8C,
      16'h451E, 16'h18E6, 16'h6B24, 16'hE7AB, 16'h3828, 16'h8148,
      16'hD461, 16'hF494, 16'h2503, 16'h691D, 16'hFE8B, 16'h9BA7,
      16'h8B17, 16'h2920, 16'h8B5F, 16'h61B1, 16'hD391, 16'h7401,
      16'h2138, 16'h129F, 16'hB3A0, 16'h2988};

   typedef struct packed {
      logic [7:0] data;
      logic       is_rx;
      logic       last;
      logic       error;
   } codec_byte_type;

   function automatic bit [7:0] mirror(input bit [7:0] v);
      bit [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

   function automatic bit [15:0] crc_step(input bit [15:0] c_in, input bit [7:0] v);
      bit [15:0] c;
      c = c_in ^ {v, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic codec_byte_type make_byte(input bit [7:0] data, input bit is_rx,
                                                input bit error);
      codec_byte_type b;
      b.data  = data;
      b.is_rx = is_rx;
      b.last  = 1'b0;
      b.error = error;
      return b;
   endfunction

   class codec_scoreboard;
      // register mirror
      bit [39:0] address;
      bit [2:0]  addr_len;
      bit        crc_on;
      bit        native;
      // packet state
      int        tx_pos;
      int        rx_pos;
      bit [15:0] crc;
      bit        header_done;

      codec_byte_type awaited_bytes[$];
      int unsigned errors;
      int unsigned checked;

      function new();
         address     = '0;
         addr_len    = 3'd3;
         crc_on      = 1'b0;
         native      = 1'b1;
         tx_pos      = 0;
         rx_pos      = 0;
         crc         = SEED;
         header_done = 1'b0;
         errors      = 0;
         checked     = 0;
      endfunction

      function int outstanding();
         return awaited_bytes.size();
      endfunction

      function void write_reg(input bit [1:0] index, input bit [39:0] value);
         case (index)
            spc_pkg::CSR_TX_ADDRESS:     address  = value;
            spc_pkg::CSR_ADDRESS_LENGTH: addr_len = value[2:0];
            spc_pkg::CSR_CRC_ENABLE:     crc_on   = value[0];
            spc_pkg::CSR_NATIVE_MODE:    native   = value[0];
            default: ;
         endcase
      endfunction

      // Works out every response byte that one accepted request causes.
      function void note_request(input bit kind, input bit [7:0] data, input bit last,
                                 input bit no_data);
         codec_byte_type burst[$];
         codec_byte_type tail;
         bit          present;
         int          al;
         int          hl;
         int          need;
         int          fix;
         bit [7:0]    e;
         bit [15:0]   c;
         present = !(last && no_data);
         al = (addr_len < 3) ? 3 : ((addr_len > 5) ? 5 : int'(addr_len));
         if (kind) begin
            if (present) begin
               if (rx_pos < MAX_PACKET && al + rx_pos < SCRAMBLE_LEN) begin
                  e = mirror(data) ^ mirror(SCRAMBLE[al + rx_pos]);
                  burst.push_back(make_byte(e, 1'b1, 1'b0));
                  rx_pos++;
               end else begin
                  burst.push_back(make_byte(8'h00, 1'b1, 1'b1));
               end
            end
            if (last) rx_pos = 0;
         end else if (native) begin
            if (present) begin
               if (tx_pos < MAX_PACKET) begin
                  burst.push_back(make_byte(data, 1'b0, 1'b0));
                  tx_pos++;
               end else begin
                  burst.push_back(make_byte(8'h00, 1'b0, 1'b1));
               end
            end
            if (last) begin
               tx_pos      = 0;
               header_done = 1'b0;
               crc         = SEED;
            end
         end else begin
            hl = al + ((al < 4) ? 1 : 0);
            if (!header_done) begin
               if (al < 4) burst.push_back(make_byte(SYNC_BYTE, 1'b0, 1'b0));
               for (int i = 0; i < al; i++) begin
                  e = address[8*(al-1-i) +: 8] ^ SCRAMBLE[i];
                  burst.push_back(make_byte(e, 1'b0, 1'b0));
                  crc = crc_step(crc, e);
               end
               header_done = 1'b1;
            end
            if (present) begin
               need = hl + tx_pos + 1 + (crc_on ? 2 : 0);
               if (need <= MAX_PACKET && al + tx_pos < SCRAMBLE_LEN) begin
                  e = mirror(data) ^ SCRAMBLE[al + tx_pos];
                  burst.push_back(make_byte(e, 1'b0, 1'b0));
                  crc = crc_step(crc, e);
                  tx_pos++;
               end else begin
                  burst.push_back(make_byte(8'h00, 1'b0, 1'b1));
               end
            end
            if (last) begin
               if (crc_on) begin
                  fix = al - 3 + tx_pos;
                  if (fix > CRC_FIX_LEN - 1) fix = CRC_FIX_LEN - 1;
                  c = crc ^ CRC_FIX[fix];
                  burst.push_back(make_byte(c[15:8], 1'b0, 1'b0));
                  burst.push_back(make_byte(c[7:0], 1'b0, 1'b0));
               end
               tx_pos      = 0;
               header_done = 1'b0;
               crc         = SEED;
            end
         end
         if (last && burst.size() > 0) begin
            tail      = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
         end
         foreach (burst[i]) awaited_bytes.push_back(burst[i]);
      endfunction

      function void compare(input string field, input logic [7:0] want, input logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(input codec_byte_type got);
         codec_byte_type want;
         if (awaited_bytes.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual byte %h rx %b last %b err %b",
                     $time, got.data, got.is_rx, got.last, got.error);
            errors++;
            return;
         end
         want = awaited_bytes.pop_front();
         checked++;
         compare("out_byte", want.data, got.data);
         compare("out_is_rx", {7'd0, want.is_rx}, {7'd0, got.is_rx});
         compare("out_last", {7'd0, want.last}, {7'd0, got.last});
         compare("out_error", {7'd0, want.error}, {7'd0, got.error});
      endfunction
   endclass

endpackage

>>> test/tb.sv
`timescale 1ns / 1ps
// Top-level testbench for the scrambled packet codec: stimulus, handshakes and checking.
module tb;
   import codec_scoreboard_pkg::*;

   // stimulus totals
   localparam int RANDOM_REQUESTS = 400;
   localparam int SETTLE_CYCLES   = 6;   // leave margin for empty closes

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        csr_wr_en     = 1'b0;
   logic [1:0]  csr_index     = spc_pkg::CSR_TX_ADDRESS;
   logic [39:0] csr_wr_data   = '0;
   logic        req_valid     = 1'b0;
   logic        req_kind      = 1'b0;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        req_no_data   = 1'b0;
   logic        rsp_ready     = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_is_rx;
   logic        rsp_out_last;
   logic        rsp_out_error;

   // calm = no idling on either side (one long stretch of the run)
   bit          calm = 1'b0;
   int unsigned requests_sent = 0;
   int unsigned csr_writes = 0;
   int unsigned settings_used = 0;

   codec_scoreboard sb = new();

   scrambled_packet_codec_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .req_no_data   (req_no_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_is_rx (rsp_out_is_rx),
      .rsp_out_last  (rsp_out_last),
      .rsp_out_error (rsp_out_error)
   );

   always #4 clock = ~clock;

   // Receiver: stalls ~12% of cycles unless in the calm stretch.
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 12);
   end

   // Response monitor. All drives are NBAs, so values read here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response('{rsp_out_byte, rsp_out_is_rx, rsp_out_last, rsp_out_error});
      end
   end

   // One request: optional idle gap, then hold valid until the accepting edge.
   task automatic send_request(input bit kind, input bit [7:0] data, input bit last,
                               input bit no_data);
      if (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(2, 1)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_data_byte <= data;
      req_last_byte <= last;
      req_no_data   <= no_data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(kind, data, last, no_data);
      requests_sent++;
   endtask

   // Stop sending, let every awaited response drain, then allow for an empty close
   // still in flight. Also serves as the sender hold-off.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input bit [1:0] index, input bit [39:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      sb.write_reg(index, value);
      csr_writes++;
   endtask

   task automatic configure(input bit [39:0] address, input bit [2:0] addr_len,
                            input bit crc_on, input bit native);
      settle();
      write_reg(spc_pkg::CSR_TX_ADDRESS, address);
      write_reg(spc_pkg::CSR_ADDRESS_LENGTH, {37'd0, addr_len});
      write_reg(spc_pkg::CSR_CRC_ENABLE, {39'd0, crc_on});
      write_reg(spc_pkg::CSR_NATIVE_MODE, {39'd0, native});
      settings_used++;
   endtask

   // A packet of random bytes. no_data on inner bytes must be ignored by the block.
   // Now and then a request of the other direction sneaks in, and once in a while
   // the CRC or mode bit is flipped in the middle of the packet.
   task automatic send_packet(input bit kind, input int len, input bit empty_close);
      bit [1:0] which;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 5) begin
            send_request(!kind, 8'($urandom()), 1'b0, 1'($urandom()));
         end
         if (i == len / 2 && len > 2 && $urandom_range(7) == 0) begin
            settle();
            which = ($urandom_range(1) == 0) ? spc_pkg::CSR_CRC_ENABLE
                                             : spc_pkg::CSR_NATIVE_MODE;
            write_reg(which, {39'd0, 1'($urandom())});
         end
         send_request(kind, 8'($urandom()), (i == len - 1) && !empty_close,
                      1'($urandom()));
      end
      if (empty_close || len == 0) begin
         send_request(kind, 8'($urandom()), 1'b1, 1'b1);
      end
   endtask

   initial begin
      int          directed_count;
      int          phase;
      int          len;
      int          r;
      bit [39:0]   address;
      bit [2:0]    addr_len;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // Reset state is native mode: bytes pass through, extremes first.
      send_request(1'b0, 8'h00, 1'b0, 1'b0);
      send_request(1'b0, 8'hff, 1'b1, 1'b0);
      // native close with no byte: nothing comes out
      send_request(1'b0, 8'ha5, 1'b1, 1'b1);
      // receive decoding, no_data without last treated as plain payload,
      // then a receive close with no byte
      send_request(1'b1, 8'h00, 1'b0, 1'b0);
      send_request(1'b1, 8'hff, 1'b0, 1'b0);
      send_request(1'b1, 8'h5a, 1'b0, 1'b1);
      send_request(1'b1, 8'h3c, 1'b1, 1'b1);

      // Emulated, 5-byte all-ones address, CRC on: header without preamble.
      configure(40'hff_ffff_ffff, 3'd5, 1'b1, 1'b0);
      send_request(1'b0, 8'h00, 1'b0, 1'b0);
      send_request(1'b0, 8'hff, 1'b1, 1'b0);
      // empty packet: header and CRC only
      send_request(1'b0, 8'h77, 1'b1, 1'b1);

      // Emulated, zero address, 3 bytes, no CRC: preamble comes first.
      configure(40'h0, 3'd3, 1'b0, 1'b0);
      send_request(1'b0, 8'h81, 1'b1, 1'b0);
      // close with no byte emits just the header
      send_request(1'b0, 8'h81, 1'b1, 1'b1);
      // close after the header went out: no response at all
      send_request(1'b0, 8'h3c, 1'b0, 1'b0);
      send_request(1'b0, 8'hc3, 1'b1, 1'b1);

      configure({8'($urandom()), 32'($urandom())}, 3'd4, 1'b1, 1'b0);
      send_request(1'b0, 8'h12, 1'b1, 1'b0);
      send_request(1'b1, 8'h34, 1'b1, 1'b0);

      // address length out of range: 0 behaves as 3, 7 as 5
      configure({8'($urandom()), 32'($urandom())}, 3'd0, 1'b1, 1'b0);
      send_request(1'b0, 8'h9e, 1'b1, 1'b0);
      send_request(1'b1, 8'h9e, 1'b1, 1'b0);
      configure({8'($urandom()), 32'($urandom())}, 3'd7, 1'b1, 1'b0);
      send_request(1'b0, 8'h61, 1'b1, 1'b0);
      send_request(1'b1, 8'h61, 1'b1, 1'b0);
      directed_count = requests_sent;

      // ---- random part ----
      // Long emulated packet without CRC fills the limit and drops a byte; CRC is
      // then enabled before the close, so the CRC table index runs off the end.
      configure({8'($urandom()), 32'($urandom())}, 3'd5, 1'b0, 1'b0);
      for (int i = 0; i < 28; i++) begin
         send_request(1'b0, 8'($urandom()), 1'b0, 1'($urandom()));
      end
      settle();
      write_reg(spc_pkg::CSR_CRC_ENABLE, 40'd1);
      send_request(1'b0, 8'($urandom()), 1'b1, 1'b1);

      phase = 0;
      while (requests_sent < directed_count + RANDOM_REQUESTS) begin
         r = $urandom_range(3);
         address = (r == 0) ? 40'h0 : (r == 1) ? 40'hff_ffff_ffff
                 : {8'($urandom()), 32'($urandom())};
         addr_len = ($urandom_range(99) < 80) ? 3'($urandom_range(5, 3))
                                              : 3'($urandom_range(7));
         configure(address, addr_len, 1'($urandom()), $urandom_range(99) < 30);
         calm = (phase == 2);   // one long stretch with no idling
         repeat ($urandom_range(5, 3)) begin
            r = $urandom_range(99);
            len = (r < 60) ? $urandom_range(8, 1)
                : (r < 85) ? $urandom_range(24, 9) : $urandom_range(36, 25);
            send_packet($urandom_range(99) < 40, len, $urandom_range(99) < 20);
         end
         phase++;
      end
      calm = 1'b0;

      // ---- wind down ----
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Ran %0d requests (%0d directed) over %0d register settings, %0d CSR writes;",
               requests_sent, directed_count, settings_used, csr_writes);
      $display("%0d responses checked against the predictor, %0d field errors.",
               sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("Timeout with %0d responses still awaited", sb.outstanding());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
